FILE: rtl/core/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// Shared codes and fixed field widths of the trilinear volume sampler.
// ----------------------------------------------------------------------------
package tvs_pkg;

  localparam int unsigned VOX_W = 16;  // voxel and sample width
  localparam int unsigned IDX_W = 5;   // write index width per axis
  localparam int unsigned POS_W = 24;  // fixed-point position width
  localparam int unsigned CFG_W = 6;   // dimension register width
  localparam int unsigned CFG_IDX_W = 2;

  // Request kinds carried in tuser.
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 6'd32;

  localparam logic signed [VOX_W-1:0] SAT_MIN = -16'sd32768;
  localparam logic signed [VOX_W-1:0] SAT_MAX = 16'sd32767;

  localparam int unsigned IN_DATA_W  = 104;  // 103 bits of fields, padded
  localparam int unsigned OUT_DATA_W = 16;

endpackage

FILE: rtl/core/trilinear_volume_sampler.sv
// ----------------------------------------------------------------------------
// trilinear_volume_sampler
// Voxel store with a pipelined trilinear interpolator behind it.
// ----------------------------------------------------------------------------
// The block keeps a cube of signed 16-bit voxels, MAX_DIM on a side, in eight
// RAM banks selected by the parity of each coordinate, so the eight corners
// of a sample are read in the same cycle. A request with tuser low writes one
// voxel at once on acceptance and returns nothing; a request with tuser high
// returns one interpolated sample. Samples run through six register stages
// (clamp, bank read, x blend, y blend, z blend, round and saturate), so a
// request can be accepted every cycle when the output side does not stall.
// Each stage keeps its own valid bit and moves whenever the stage after it
// is free, so a waiting result does not block requests that fill empty
// stages. The voxel store has no reset; a sample must only touch voxels
// written before. Dimension registers are written through the cfg channel;
// the user must write them only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module trilinear_volume_sampler #(
  parameter int unsigned MAX_DIM   = 32,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request stream.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata, lowest bit up: voxel_x[4:0], voxel_y[9:5], voxel_z[14:10],
  // voxel_value[30:15], pos_x[54:31], pos_y[78:55], pos_z[102:79], zero pad.
  input  logic [tvs_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // tuser: req_type.
  input  logic                                s_axis_tuser_i,
  // Result stream.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata: sample_value[15:0].
  output logic [tvs_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tvs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tvs_pkg::CFG_W-1:0]           cfg_data_i
);
  import tvs_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_DIM);
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned CB    = (CW > 1) ? CW - 1 : 1;
  localparam int unsigned BA    = 3 * CB;
  localparam int unsigned BDEP  = 2 ** BA;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned AW    = VOX_W + F + 1;
  localparam int unsigned BW    = AW + F + 1;
  localparam int unsigned TW    = BW + F + 1;
  localparam int unsigned SH    = 3 * F;
  localparam int unsigned NST   = 6;
  localparam int unsigned IW    = (DW > IDX_W) ? DW : IDX_W;

  // Stage numbers along the sample pipeline.
  localparam int unsigned ST_CLAMP = 0;
  localparam int unsigned ST_READ  = 1;
  localparam int unsigned ST_XB    = 2;
  localparam int unsigned ST_YB    = 3;
  localparam int unsigned ST_ZB    = 4;
  localparam int unsigned ST_OUT   = 5;

  // Unpacked request fields.
  logic [IDX_W-1:0]               vx, vy, vz;
  logic signed [VOX_W-1:0]        vval;
  logic signed [POS_W-1:0]        pos [3];

  assign vx     = s_axis_tdata_i[4:0];
  assign vy     = s_axis_tdata_i[9:5];
  assign vz     = s_axis_tdata_i[14:10];
  assign vval   = s_axis_tdata_i[30:15];
  assign pos[0] = s_axis_tdata_i[54:31];
  assign pos[1] = s_axis_tdata_i[78:55];
  assign pos[2] = s_axis_tdata_i[102:79];

  // Dimension registers and their effective values.
  logic [CFG_W-1:0] dim_q [3];
  logic [DW-1:0]    dim_eff [3];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q[0] <= DIM_RESET;
      dim_q[1] <= DIM_RESET;
      dim_q[2] <= DIM_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_DIM_X: dim_q[0] <= cfg_data_i;
        REG_DIM_Y: dim_q[1] <= cfg_data_i;
        REG_DIM_Z: dim_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero dimension acts as one, anything above MAX_DIM acts as MAX_DIM.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (dim_q[a] == '0) begin
        dim_eff[a] = DW'(1);
      end else if ({{DW{1'b0}}, dim_q[a]} > (DW+CFG_W)'(MAX_DIM)) begin
        dim_eff[a] = DW'(MAX_DIM);
      end else begin
        dim_eff[a] = DW'(dim_q[a]);
      end
    end
  end

  // Stage advance: a stage moves when it is empty or the next one moves.
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[ST_OUT] = !v_q[ST_OUT] || m_axis_tready_i;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  logic acc;
  logic acc_sample;
  assign s_axis_tready_o = en[ST_CLAMP];
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;
  assign acc_sample      = acc && (s_axis_tuser_i == REQ_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[ST_CLAMP]) begin
        v_q[ST_CLAMP] <= acc_sample;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Voxel writes go to the bank picked by the coordinate parities.
  logic          wr_ok;
  logic [IW-1:0] wx, wy, wz;
  logic [2:0]    wbank;
  logic [BA-1:0] waddr;

  always_comb begin
    wx = IW'(vx);
    wy = IW'(vy);
    wz = IW'(vz);
    wr_ok = acc && (s_axis_tuser_i == REQ_WRITE) && (wx < IW'(MAX_DIM))
            && (wy < IW'(MAX_DIM)) && (wz < IW'(MAX_DIM));
    wbank = {wz[0], wy[0], wx[0]};
    waddr = {CB'(wz >> 1), CB'(wy >> 1), CB'(wx >> 1)};
  end

  // Stage 0: clamp and corner selection per axis.
  logic [CW-1:0] lo_d [3];
  logic [CW-1:0] hi_d [3];
  logic [F-1:0]  fr_d [3];
  logic [CW-1:0] lo_q [3];
  logic [CW-1:0] hi_q [3];
  logic [F-1:0]  fr_q [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    tvs_axis #(
      .MAX_DIM  (MAX_DIM),
      .FRAC_BITS(FRAC_BITS)
    ) u_axis (
      .pos_i (pos[a]),
      .dim_i (dim_eff[a]),
      .lo_o  (lo_d[a]),
      .hi_o  (hi_d[a]),
      .frac_o(fr_d[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_CLAMP]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      fr_q <= fr_d;
    end
  end

  // Stage 1: bank reads. Each bank reads whichever corner has its parity.
  logic [VOX_W-1:0] bank_rd [8];
  logic [1:0]       par_q [3];
  logic [F-1:0]     frb_q [3];

  for (genvar b = 0; b < 8; b++) begin : g_bank
    localparam logic [2:0] BI = 3'(b);
    logic [CW-1:0] rx, ry, rz;
    logic [BA-1:0] raddr;
    assign rx    = (lo_q[0][0] == BI[0]) ? lo_q[0] : hi_q[0];
    assign ry    = (lo_q[1][0] == BI[1]) ? lo_q[1] : hi_q[1];
    assign rz    = (lo_q[2][0] == BI[2]) ? lo_q[2] : hi_q[2];
    assign raddr = {CB'(rz >> 1), CB'(ry >> 1), CB'(rx >> 1)};

    tvs_ram #(
      .WIDTH(VOX_W),
      .DEPTH(BDEP)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_ok && (wbank == BI)),
      .waddr_i(waddr),
      .wdata_i(vval),
      .re_i   (en[ST_READ]),
      .raddr_i(raddr),
      .rdata_o(bank_rd[b])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_READ]) begin
      for (int a = 0; a < 3; a++) begin
        par_q[a] <= {hi_q[a][0], lo_q[a][0]};
      end
      frb_q <= fr_q;
    end
  end

  // Stage 2: blend along x. Corner index is {z, y, x}.
  logic signed [VOX_W-1:0] corner [8];
  logic signed [F+1:0]     wx_lo, wx_hi;
  logic signed [AW:0]      pa [4];
  logic signed [AW-1:0]    a_q [4];
  logic [F-1:0]            fyc_q, fzc_q;

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      corner[c] = $signed(bank_rd[{par_q[2][c/4], par_q[1][(c/2)%2], par_q[0][c%2]}]);
    end
    wx_hi = $signed({2'b00, frb_q[0]});
    wx_lo = $signed((F+2)'(1) << F) - wx_hi;
    for (int j = 0; j < 4; j++) begin
      pa[j] = corner[2*j] * wx_lo + corner[2*j+1] * wx_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_XB]) begin
      for (int j = 0; j < 4; j++) begin
        a_q[j] <= pa[j][AW-1:0];
      end
      fyc_q <= frb_q[1];
      fzc_q <= frb_q[2];
    end
  end

  // Stage 3: blend along y.
  logic signed [F+1:0]  wy_lo, wy_hi;
  logic signed [BW:0]   pb [2];
  logic signed [BW-1:0] b_q [2];
  logic [F-1:0]         fzd_q;

  always_comb begin
    wy_hi = $signed({2'b00, fyc_q});
    wy_lo = $signed((F+2)'(1) << F) - wy_hi;
    for (int j = 0; j < 2; j++) begin
      pb[j] = a_q[2*j] * wy_lo + a_q[2*j+1] * wy_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_YB]) begin
      b_q[0] <= pb[0][BW-1:0];
      b_q[1] <= pb[1][BW-1:0];
      fzd_q  <= fzc_q;
    end
  end

  // Stage 4: blend along z.
  logic signed [F+1:0]  wz_lo, wz_hi;
  logic signed [TW:0]   pt;
  logic signed [TW-1:0] t_q;

  always_comb begin
    wz_hi = $signed({2'b00, fzd_q});
    wz_lo = $signed((F+2)'(1) << F) - wz_hi;
    pt    = b_q[0] * wz_lo + b_q[1] * wz_hi;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_ZB]) begin
      t_q <= pt[TW-1:0];
    end
  end

  // Stage 5: round half away from zero, then saturate.
  logic [TW-1:0]    mag;
  logic [TW-1:0]    qv;
  logic [VOX_W-1:0] res_d;
  logic [VOX_W-1:0] res_q;

  always_comb begin
    mag = t_q[TW-1] ? TW'(-t_q) : TW'(t_q);
    qv  = (mag + (TW'(1) << (SH - 1))) >> SH;
    if (!t_q[TW-1]) begin
      res_d = (qv > TW'(32767)) ? SAT_MAX : qv[VOX_W-1:0];
    end else begin
      res_d = (qv > TW'(32768)) ? SAT_MIN : VOX_W'(-qv[VOX_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = v_q[ST_OUT];
  assign m_axis_tdata_o  = res_q;

`ifndef SYNTHESIS
  // A stalled clamp stage keeps its request.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_CLAMP] && !en[ST_READ]) |=> v_q[ST_CLAMP])
    else $error("clamp stage lost a request while stalled");

  // A full z blend stage that moves always fills the output register.
  a_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_ZB] && en[ST_OUT]) |=> m_axis_tvalid_o)
    else $error("result dropped between z blend and output");

  // Voxel writes happen only for accepted write requests.
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ok |-> (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == REQ_WRITE)))
    else $error("voxel written without an accepted write request");
`endif

endmodule

FILE: rtl/core/tvs_ram.sv
// ----------------------------------------------------------------------------
// tvs_ram
// Generic single-write, single-read RAM with a registered, read-first output.
// ----------------------------------------------------------------------------
module tvs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tvs_axis.sv
// ----------------------------------------------------------------------------
// tvs_axis
// Clamps one fixed-point coordinate and yields the floor corner, the next
// corner and the fractional weight.
// ----------------------------------------------------------------------------
module tvs_axis #(
  parameter int unsigned MAX_DIM   = 32,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic signed [tvs_pkg::POS_W-1:0]     pos_i,
  input  logic [$clog2(MAX_DIM+1)-1:0]         dim_i,
  output logic [$clog2(MAX_DIM)-1:0]           lo_o,
  output logic [$clog2(MAX_DIM)-1:0]           hi_o,
  output logic [FRAC_BITS-1:0]                 frac_o
);
  import tvs_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIM);
  localparam int unsigned DW = $clog2(MAX_DIM + 1);
  localparam int unsigned TW = DW + FRAC_BITS;
  localparam int unsigned EW = ((POS_W > TW) ? POS_W : TW) + 1;

  logic [DW-1:0]          dim_m1;
  logic signed [EW-1:0]   pos_ext;
  logic signed [EW-1:0]   top_ext;
  logic signed [EW-1:0]   clamped;
  logic [DW-1:0]          lo_w;
  logic [DW-1:0]          next_w;

  always_comb begin
    dim_m1  = dim_i - DW'(1);
    pos_ext = $signed({{(EW-POS_W){pos_i[POS_W-1]}}, pos_i});
    top_ext = $signed({{(EW-TW){1'b0}}, dim_m1, {FRAC_BITS{1'b0}}});
    if (pos_i[POS_W-1]) begin
      clamped = '0;
    end else if (pos_ext > top_ext) begin
      clamped = top_ext;
    end else begin
      clamped = pos_ext;
    end
    lo_w   = DW'(clamped[CW+FRAC_BITS-1:FRAC_BITS]);
    next_w = lo_w + DW'(1);
    lo_o   = lo_w[CW-1:0];
    hi_o   = (next_w < dim_i) ? next_w[CW-1:0] : dim_m1[CW-1:0];
    frac_o = clamped[FRAC_BITS-1:0];
  end

endmodule
